FILE: rtl/core/aavr_pkg.sv
package aavr_pkg;

   localparam int COORD_WIDTH_DEF = 16;
   localparam int ANGLE_WIDTH     = 16;
   localparam int OUT_WIDTH       = 18;
   localparam int FRAC_BITS       = 14;
   localparam int TRIG_WIDTH      = 16;
   localparam int OCT_WIDTH       = 14;
   localparam int PHASE_WIDTH     = 28;

   // sine/cosine pipeline depth, and whole-block latency from accept to result strobe
   localparam int SINCOS_LATENCY  = 9;
   localparam int PIPE_LATENCY    = SINCOS_LATENCY + 4;

   // octant offset to radians: Q40 step, rounded half up to Q28
   localparam logic [26:0] STEP_RAD_Q40 = 27'd105414358;
   localparam int          STEP_SHIFT   = 12;
   localparam logic [40:0] STEP_ROUND   = 41'd2048;

   localparam logic [PHASE_WIDTH:0] Q28_ONE = 29'h1000_0000;
   localparam logic [63:0]          Q28_HALF = 64'h0000_0000_0800_0000;

   // exact reciprocals for dividends below 2^28: ceil(2^(28+ceil(log2 d)) / d)
   localparam int SHIFT_42 = 34;
   localparam int SHIFT_20 = 33;
   localparam int SHIFT_6  = 31;
   localparam int SHIFT_56 = 34;
   localparam int SHIFT_30 = 33;
   localparam int SHIFT_12 = 32;
   localparam logic [PHASE_WIDTH:0] RCP_42 = 29'(((64'd1 << SHIFT_42) + 64'd41) / 64'd42);
   localparam logic [PHASE_WIDTH:0] RCP_20 = 29'(((64'd1 << SHIFT_20) + 64'd19) / 64'd20);
   localparam logic [PHASE_WIDTH:0] RCP_6  = 29'(((64'd1 << SHIFT_6) + 64'd5) / 64'd6);
   localparam logic [PHASE_WIDTH:0] RCP_56 = 29'(((64'd1 << SHIFT_56) + 64'd55) / 64'd56);
   localparam logic [PHASE_WIDTH:0] RCP_30 = 29'(((64'd1 << SHIFT_30) + 64'd29) / 64'd30);
   localparam logic [PHASE_WIDTH:0] RCP_12 = 29'(((64'd1 << SHIFT_12) + 64'd11) / 64'd12);

   // output rounding and saturation on the Q56 sum
   localparam logic [63:0] SAT_BIAS = 64'h4000_0200_0000_0000;
   localparam logic [21:0] SAT_LO   = 22'd917504;
   localparam logic [21:0] SAT_HI   = 22'd1179647;

   typedef enum logic [1:0] {
      QUAD_0,
      QUAD_1,
      QUAD_2,
      QUAD_3
   } quad_type;

   typedef struct packed {
      logic     valid;
      quad_type quad;
      logic     swap;
   } sc_ctrl_type;

   typedef struct packed {
      logic                         valid;
      logic signed [TRIG_WIDTH-1:0] sin_q14;
      logic signed [TRIG_WIDTH-1:0] cos_q14;
   } sc_result_type;

endpackage

FILE: rtl/core/aavr_sincos.sv
module aavr_sincos
   import aavr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  sc_ctrl_type          ctrl_in,
   input  logic [OCT_WIDTH-1:0] oct_in,
   output sc_result_type        result
);

   function automatic logic [PHASE_WIDTH-1:0] div_by(input logic [PHASE_WIDTH-1:0] v,
                                                     input logic [PHASE_WIDTH:0]   rcp,
                                                     input int                     sh);
      return PHASE_WIDTH'((64'(v) * 64'(rcp)) >> sh);
   endfunction

   function automatic logic [PHASE_WIDTH-1:0] mul_q28(input logic [PHASE_WIDTH-1:0] v,
                                                      input logic [PHASE_WIDTH-1:0] q);
      logic [PHASE_WIDTH:0] p;
      p = Q28_ONE - (PHASE_WIDTH+1)'(q);
      return PHASE_WIDTH'((64'(v) * 64'(p)) >> PHASE_WIDTH);
   endfunction

   sc_ctrl_type ctl_ff [0:SINCOS_LATENCY-2];
   logic        res_valid_ff;

   logic [PHASE_WIDTH-1:0] x_ff  [0:6];
   logic [PHASE_WIDTH-1:0] x2_ff [0:5];

   logic [PHASE_WIDTH-1:0] x_in, x2_in;
   logic [PHASE_WIDTH-1:0] qs1_ff, qc1_ff, qs1_in, qc1_in;
   logic [PHASE_WIDTH-1:0] ps1_ff, pc1_ff, ps1_in, pc1_in;
   logic [PHASE_WIDTH-1:0] qs2_ff, qc2_ff, qs2_in, qc2_in;
   logic [PHASE_WIDTH-1:0] ps2_ff, pc2_ff, ps2_in, pc2_in;
   logic [PHASE_WIDTH-1:0] qs3_ff, qc3_ff, qs3_in, qc3_in;
   logic [PHASE_WIDTH-1:0] sn_ff, cp_ff, sn_in, cp_in;

   logic [FRAC_BITS:0]            sv, cv;
   logic [PHASE_WIDTH:0]          cs;
   logic signed [TRIG_WIDTH-1:0]  s0, c0;
   logic signed [TRIG_WIDTH-1:0]  sin_in, cos_in, sin_ff, cos_ff;

   always_comb begin
      x_in  = PHASE_WIDTH'((41'(oct_in) * 41'(STEP_RAD_Q40) + STEP_ROUND) >> STEP_SHIFT);
      x2_in = PHASE_WIDTH'((64'(x_ff[0]) * 64'(x_ff[0]) + Q28_HALF) >> PHASE_WIDTH);

      qs1_in = div_by(x2_ff[0], RCP_42, SHIFT_42);
      qc1_in = div_by(x2_ff[0], RCP_56, SHIFT_56);
      ps1_in = mul_q28(x2_ff[1], qs1_ff);
      pc1_in = mul_q28(x2_ff[1], qc1_ff);
      qs2_in = div_by(ps1_ff, RCP_20, SHIFT_20);
      qc2_in = div_by(pc1_ff, RCP_30, SHIFT_30);
      ps2_in = mul_q28(x2_ff[3], qs2_ff);
      pc2_in = mul_q28(x2_ff[3], qc2_ff);
      qs3_in = div_by(ps2_ff, RCP_6, SHIFT_6);
      qc3_in = div_by(pc2_ff, RCP_12, SHIFT_12);
      sn_in  = mul_q28(x_ff[6], qs3_ff);
      cp_in  = mul_q28(x2_ff[5], qc3_ff);
   end

   // round to Q14, undo the octant fold, then apply the quadrant
   always_comb begin
      sv = (FRAC_BITS+1)'(((PHASE_WIDTH+1)'(sn_ff) + (PHASE_WIDTH+1)'(1 << (FRAC_BITS-1)))
                          >> FRAC_BITS);
      cs = Q28_ONE - (PHASE_WIDTH+1)'(cp_ff >> 1);
      cv = (FRAC_BITS+1)'(((PHASE_WIDTH+2)'(cs) + (PHASE_WIDTH+2)'(1 << (FRAC_BITS-1)))
                          >> FRAC_BITS);
      if (ctl_ff[SINCOS_LATENCY-2].swap) begin
         s0 = TRIG_WIDTH'(cv);
         c0 = TRIG_WIDTH'(sv);
      end else begin
         s0 = TRIG_WIDTH'(sv);
         c0 = TRIG_WIDTH'(cv);
      end
      unique case (ctl_ff[SINCOS_LATENCY-2].quad)
         QUAD_0: begin
            sin_in = s0;
            cos_in = c0;
         end
         QUAD_1: begin
            sin_in = c0;
            cos_in = -s0;
         end
         QUAD_2: begin
            sin_in = -s0;
            cos_in = -c0;
         end
         QUAD_3: begin
            sin_in = -c0;
            cos_in = s0;
         end
         default: begin
            sin_in = s0;
            cos_in = c0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SINCOS_LATENCY-1; i++) begin
            ctl_ff[i] <= '0;
         end
         res_valid_ff <= 1'b0;
      end else begin
         ctl_ff[0] <= ctrl_in;
         for (int i = 1; i < SINCOS_LATENCY-1; i++) begin
            ctl_ff[i] <= ctl_ff[i-1];
         end
         res_valid_ff <= ctl_ff[SINCOS_LATENCY-2].valid;
      end
   end

   always_ff @(posedge clock) begin
      x_ff[0] <= x_in;
      for (int i = 1; i < 7; i++) begin
         x_ff[i] <= x_ff[i-1];
      end
      x2_ff[0] <= x2_in;
      for (int i = 1; i < 6; i++) begin
         x2_ff[i] <= x2_ff[i-1];
      end
      qs1_ff <= qs1_in;
      qc1_ff <= qc1_in;
      ps1_ff <= ps1_in;
      pc1_ff <= pc1_in;
      qs2_ff <= qs2_in;
      qc2_ff <= qc2_in;
      ps2_ff <= ps2_in;
      pc2_ff <= pc2_in;
      qs3_ff <= qs3_in;
      qc3_ff <= qc3_in;
      sn_ff  <= sn_in;
      cp_ff  <= cp_in;
      sin_ff <= sin_in;
      cos_ff <= cos_in;
   end

   assign result.valid   = res_valid_ff;
   assign result.sin_q14 = sin_ff;
   assign result.cos_q14 = cos_ff;

endmodule

FILE: rtl/core/axis_angle_vector_rotate.sv
// Axis-angle vector rotation, fully pipelined.
//
// Input: present vector, unit axis (both signed Q2.14) and angle (65536 steps
// per turn) on the req_ ports with start high; the item is taken at the clock
// edge where start is high and busy is low. busy is high only during reset and
// in the cycle after it, so from then on an item can be taken on every cycle.
//
// Output: rsp_valid strobes for one cycle with the rotated vector on rsp_rot_x,
// rsp_rot_y, rsp_rot_z (signed Q4.14, saturated). Results come back in order;
// throughput is one item per cycle. The latency is set by the sine/cosine
// series: three multiply steps, each an exact reciprocal multiply followed by
// a product, all on separate stages.
//
// The receiver cannot stall: every result is shown for exactly one cycle.
// Reset clears all valid bits, so items in flight are dropped; no other state
// is kept between items.
module axis_angle_vector_rotate
   import aavr_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [COORD_WIDTH-1:0] req_vec_x,
   input  logic signed [COORD_WIDTH-1:0] req_vec_y,
   input  logic signed [COORD_WIDTH-1:0] req_vec_z,
   input  logic signed [COORD_WIDTH-1:0] req_axis_x,
   input  logic signed [COORD_WIDTH-1:0] req_axis_y,
   input  logic signed [COORD_WIDTH-1:0] req_axis_z,
   input  logic [ANGLE_WIDTH-1:0]        req_angle,
   output logic                          rsp_valid,
   output logic signed [OUT_WIDTH-1:0]   rsp_rot_x,
   output logic signed [OUT_WIDTH-1:0]   rsp_rot_y,
   output logic signed [OUT_WIDTH-1:0]   rsp_rot_z
);

   localparam int W         = COORD_WIDTH;
   localparam int PROD_W    = 2*W;
   localparam int DOT_W     = 2*W + 2;
   localparam int CROSS_W   = 2*W + 1;
   localparam int UD_W      = 3*W + 2;
   localparam int OC_W      = TRIG_WIDTH + 1;
   localparam int T1_W      = W + TRIG_WIDTH;
   localparam int T2_W      = UD_W + OC_W;
   localparam int T3_W      = CROSS_W + TRIG_WIDTH;
   localparam int SUM_W     = 3*W + 48;
   localparam int GEO_DELAY = SINCOS_LATENCY - 2;

   localparam logic signed [OC_W-1:0] ONE_Q14 = OC_W'(1 << FRAC_BITS);

   typedef struct packed {
      logic signed [W-1:0]       a_x;
      logic signed [W-1:0]       a_y;
      logic signed [W-1:0]       a_z;
      logic signed [UD_W-1:0]    ud_x;
      logic signed [UD_W-1:0]    ud_y;
      logic signed [UD_W-1:0]    ud_z;
      logic signed [CROSS_W-1:0] cr_x;
      logic signed [CROSS_W-1:0] cr_y;
      logic signed [CROSS_W-1:0] cr_z;
   } geo_type;

   // Q56 sum to Q14 with round half up, then clamp to the output range
   function automatic logic signed [OUT_WIDTH-1:0] to_out(input logic signed [SUM_W-1:0] s);
      logic [63:0] u;
      logic [21:0] t;
      u = s[63:0] + SAT_BIAS;
      t = u[63:42];
      priority if (t < SAT_LO) begin
         return {1'b1, {(OUT_WIDTH-1){1'b0}}};
      end else if (t > SAT_HI) begin
         return {1'b0, {(OUT_WIDTH-1){1'b1}}};
      end else begin
         return signed'(t[OUT_WIDTH-1:0]);
      end
   endfunction

   logic busy_ff;
   logic accept;

   // stage 1: fold angle into an octant, axis/vector products
   sc_ctrl_type          ctl1_in, ctl1_ff;
   logic [OCT_WIDTH-1:0] oct1_in, oct1_ff;
   logic [OCT_WIDTH-1:0] frac;
   logic signed [W-1:0]      a1_ff [0:2];
   logic signed [W-1:0]      u1_ff [0:2];
   logic signed [PROD_W-1:0] dp1_ff [0:2];
   logic signed [PROD_W-1:0] cp1_ff [0:5];

   // stage 2: dot and cross products
   logic signed [W-1:0]       a2_ff  [0:2];
   logic signed [W-1:0]       u2_ff  [0:2];
   logic signed [DOT_W-1:0]   dot2_ff;
   logic signed [CROSS_W-1:0] cr2_ff [0:2];

   // stage 3 and delay line to meet the sine/cosine result
   geo_type geo3_in, geo3_ff;
   geo_type geo_ff [0:GEO_DELAY-1];

   sc_result_type sc;

   // stage 11: the three terms of each component
   logic                       v11_ff;
   logic signed [OC_W-1:0]     oc;
   logic signed [T1_W-1:0]     t1_ff [0:2];
   logic signed [T2_W-1:0]     t2_ff [0:2];
   logic signed [T3_W-1:0]     t3_ff [0:2];

   // stage 12: sums; stage 13: output registers
   logic                       v12_ff;
   logic signed [SUM_W-1:0]    sum_in [0:2];
   logic signed [SUM_W-1:0]    sum_ff [0:2];
   logic                       rsp_valid_ff;
   logic signed [OUT_WIDTH-1:0] rot_ff [0:2];

   assign accept = start && !busy_ff;
   assign busy   = busy_ff;

   always_comb begin
      frac         = req_angle[OCT_WIDTH-1:0];
      ctl1_in.valid = accept;
      ctl1_in.quad  = quad_type'(req_angle[ANGLE_WIDTH-1 -: 2]);
      if (frac[OCT_WIDTH-1]) begin
         ctl1_in.swap = 1'b1;
         oct1_in      = OCT_WIDTH'((OCT_WIDTH+1)'(1 << OCT_WIDTH) - (OCT_WIDTH+1)'(frac));
      end else begin
         ctl1_in.swap = 1'b0;
         oct1_in      = frac;
      end
   end

   always_comb begin
      geo3_in.a_x  = a2_ff[0];
      geo3_in.a_y  = a2_ff[1];
      geo3_in.a_z  = a2_ff[2];
      geo3_in.ud_x = UD_W'(u2_ff[0]) * UD_W'(dot2_ff);
      geo3_in.ud_y = UD_W'(u2_ff[1]) * UD_W'(dot2_ff);
      geo3_in.ud_z = UD_W'(u2_ff[2]) * UD_W'(dot2_ff);
      geo3_in.cr_x = cr2_ff[0];
      geo3_in.cr_y = cr2_ff[1];
      geo3_in.cr_z = cr2_ff[2];
   end

   aavr_sincos u_sincos (
      .clock   (clock),
      .reset   (reset),
      .ctrl_in (ctl1_ff),
      .oct_in  (oct1_ff),
      .result  (sc)
   );

   // R*A = c*A + (1-c)*U*(U.A) + s*(U x A), scaled to Q56
   always_comb begin
      oc = ONE_Q14 - OC_W'(sc.cos_q14);
      for (int i = 0; i < 3; i++) begin
         sum_in[i] = (SUM_W'(t1_ff[i]) <<< (2*FRAC_BITS)) + SUM_W'(t2_ff[i])
                     + (SUM_W'(t3_ff[i]) <<< FRAC_BITS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b1;
         ctl1_ff      <= '0;
         v11_ff       <= 1'b0;
         v12_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= 1'b0;
         ctl1_ff      <= ctl1_in;
         v11_ff       <= sc.valid;
         v12_ff       <= v11_ff;
         rsp_valid_ff <= v12_ff;
      end
   end

   always_ff @(posedge clock) begin
      oct1_ff   <= oct1_in;
      a1_ff[0]  <= req_vec_x;
      a1_ff[1]  <= req_vec_y;
      a1_ff[2]  <= req_vec_z;
      u1_ff[0]  <= req_axis_x;
      u1_ff[1]  <= req_axis_y;
      u1_ff[2]  <= req_axis_z;
      dp1_ff[0] <= PROD_W'(req_axis_x) * PROD_W'(req_vec_x);
      dp1_ff[1] <= PROD_W'(req_axis_y) * PROD_W'(req_vec_y);
      dp1_ff[2] <= PROD_W'(req_axis_z) * PROD_W'(req_vec_z);
      cp1_ff[0] <= PROD_W'(req_axis_y) * PROD_W'(req_vec_z);
      cp1_ff[1] <= PROD_W'(req_axis_z) * PROD_W'(req_vec_y);
      cp1_ff[2] <= PROD_W'(req_axis_z) * PROD_W'(req_vec_x);
      cp1_ff[3] <= PROD_W'(req_axis_x) * PROD_W'(req_vec_z);
      cp1_ff[4] <= PROD_W'(req_axis_x) * PROD_W'(req_vec_y);
      cp1_ff[5] <= PROD_W'(req_axis_y) * PROD_W'(req_vec_x);

      for (int i = 0; i < 3; i++) begin
         a2_ff[i] <= a1_ff[i];
         u2_ff[i] <= u1_ff[i];
      end
      dot2_ff   <= DOT_W'(dp1_ff[0]) + DOT_W'(dp1_ff[1]) + DOT_W'(dp1_ff[2]);
      cr2_ff[0] <= CROSS_W'(cp1_ff[0]) - CROSS_W'(cp1_ff[1]);
      cr2_ff[1] <= CROSS_W'(cp1_ff[2]) - CROSS_W'(cp1_ff[3]);
      cr2_ff[2] <= CROSS_W'(cp1_ff[4]) - CROSS_W'(cp1_ff[5]);

      geo3_ff   <= geo3_in;
      geo_ff[0] <= geo3_ff;
      for (int i = 1; i < GEO_DELAY; i++) begin
         geo_ff[i] <= geo_ff[i-1];
      end

      t1_ff[0] <= T1_W'(sc.cos_q14) * T1_W'(geo_ff[GEO_DELAY-1].a_x);
      t1_ff[1] <= T1_W'(sc.cos_q14) * T1_W'(geo_ff[GEO_DELAY-1].a_y);
      t1_ff[2] <= T1_W'(sc.cos_q14) * T1_W'(geo_ff[GEO_DELAY-1].a_z);
      t2_ff[0] <= T2_W'(oc) * T2_W'(geo_ff[GEO_DELAY-1].ud_x);
      t2_ff[1] <= T2_W'(oc) * T2_W'(geo_ff[GEO_DELAY-1].ud_y);
      t2_ff[2] <= T2_W'(oc) * T2_W'(geo_ff[GEO_DELAY-1].ud_z);
      t3_ff[0] <= T3_W'(sc.sin_q14) * T3_W'(geo_ff[GEO_DELAY-1].cr_x);
      t3_ff[1] <= T3_W'(sc.sin_q14) * T3_W'(geo_ff[GEO_DELAY-1].cr_y);
      t3_ff[2] <= T3_W'(sc.sin_q14) * T3_W'(geo_ff[GEO_DELAY-1].cr_z);

      for (int i = 0; i < 3; i++) begin
         sum_ff[i] <= sum_in[i];
         rot_ff[i] <= to_out(sum_ff[i]);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_rot_x = rot_ff[0];
   assign rsp_rot_y = rot_ff[1];
   assign rsp_rot_z = rot_ff[2];

endmodule

FILE: rtl/core/aavr_checker.sv
module aavr_checker
   import aavr_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);

   // every item taken comes back after the fixed pipeline latency
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##PIPE_LATENCY rsp_valid)
      else $error("item taken but no result after pipeline latency");

   // no result without an item taken the same latency earlier
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, PIPE_LATENCY))
      else $error("result strobe without a matching item");

   // the pipeline never pushes back once out of reset
   assert property (@(posedge clock) disable iff (reset)
      $past(!reset) |-> !busy)
      else $error("busy raised outside reset");

endmodule

bind axis_angle_vector_rotate aavr_checker u_aavr_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid)
);

FILE: tb/sv/tb_axis_angle_vector_rotate.sv
`timescale 1ns / 1ps

module tb_axis_angle_vector_rotate;
   import aavr_pkg::*;

   localparam int COORD_W        = COORD_WIDTH_DEF;
   localparam int RANDOM_ITEMS   = 1250;
   localparam int DRAIN_EVERY    = 200;
   localparam int CYCLE_LIMIT    = 200000;
   localparam int SETTLE_CYCLES  = PIPE_LATENCY + 8;

   localparam bit [63:0] ONE_Q14       = 64'd16384;
   localparam bit [63:0] ONE_Q28       = 64'd1 << 28;
   localparam bit [63:0] STEP_Q40      = 64'd105414358;
   localparam bit [63:0] OCTANT_STEPS  = 64'd8192;
   localparam bit [63:0] QUARTER_STEPS = 64'd16384;
   localparam bit [63:0] ROT_BIAS      = 64'd1 << 20;
   localparam bit [63:0] ROT_FLOOR     = ROT_BIAS - 64'd131072;
   localparam bit [63:0] ROT_CEIL      = ROT_BIAS + 64'd131071;
   localparam logic signed [OUT_WIDTH-1:0] ROT_MAX = 18'sd131071;
   localparam logic signed [OUT_WIDTH-1:0] ROT_MIN = -18'sd131072;

   typedef struct {
      logic signed [COORD_W-1:0] vec_x, vec_y, vec_z;
      logic signed [COORD_W-1:0] axis_x, axis_y, axis_z;
      logic [ANGLE_WIDTH-1:0]    angle;
      int unsigned               wait_cycles;
      bit                        drain;
   } rotate_item_type;

   // index 0 is x, 1 is y, 2 is z
   typedef logic [2:0][OUT_WIDTH-1:0] rot_vec_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [COORD_W-1:0] req_vec_x = '0, req_vec_y = '0, req_vec_z = '0;
   logic signed [COORD_W-1:0] req_axis_x = '0, req_axis_y = '0, req_axis_z = '0;
   logic [ANGLE_WIDTH-1:0]    req_angle = '0;
   logic                      rsp_valid;
   logic signed [OUT_WIDTH-1:0] rsp_rot_x, rsp_rot_y, rsp_rot_z;

   rotate_item_type pending [$];
   rot_vec_type     rotations_due [$];
   rotate_item_type in_flight;
   int unsigned  idle_count = 0;
   int unsigned  burst_left = 0;
   int           items_accepted = 0;
   int           results_checked = 0;
   int           saturated = 0;
   int           drain_pauses = 0;
   int           errors = 0;
   int           cycles = 0;
   int           directed_items = 0;

   axis_angle_vector_rotate #(.COORD_WIDTH(COORD_W)) dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_vec_x  (req_vec_x),
      .req_vec_y  (req_vec_y),
      .req_vec_z  (req_vec_z),
      .req_axis_x (req_axis_x),
      .req_axis_y (req_axis_y),
      .req_axis_z (req_axis_z),
      .req_angle  (req_angle),
      .rsp_valid  (rsp_valid),
      .rsp_rot_x  (rsp_rot_x),
      .rsp_rot_y  (rsp_rot_y),
      .rsp_rot_z  (rsp_rot_z)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic bit [63:0] widen(logic signed [COORD_W-1:0] v);
      return {{(64 - COORD_W){v[COORD_W-1]}}, v};
   endfunction

   // sine and cosine of t steps (0..8192) in Q14, via truncated series in Q28
   function automatic void octant_sincos(input bit [63:0] t,
                                         output bit [63:0] sin_q14,
                                         output bit [63:0] cos_q14);
      bit [63:0] x, x2, p, sn, cs;
      x  = (t * STEP_Q40 + 64'd2048) >> 12;
      x2 = (x * x + (64'd1 << 27)) >> 28;

      p  = ONE_Q28 - x2 / 64'd42;
      p  = ONE_Q28 - ((x2 * p) >> 28) / 64'd20;
      p  = ONE_Q28 - ((x2 * p) >> 28) / 64'd6;
      sn = (x * p) >> 28;

      p  = ONE_Q28 - x2 / 64'd56;
      p  = ONE_Q28 - ((x2 * p) >> 28) / 64'd30;
      p  = ONE_Q28 - ((x2 * p) >> 28) / 64'd12;
      cs = ONE_Q28 - ((x2 * p) >> 28) / 64'd2;

      sin_q14 = (sn + 64'd8192) >> 14;
      cos_q14 = (cs + 64'd8192) >> 14;
   endfunction

   // Q56 sum to Q14, round half up, clamp to the 18-bit range
   function automatic logic [OUT_WIDTH-1:0] round_saturate(bit [63:0] sum_q56);
      bit [63:0] biased;
      biased = (sum_q56 + (64'd1 << 41) + (64'd1 << 62)) >> 42;
      if (biased < ROT_FLOOR)
         biased = ROT_FLOOR;
      if (biased > ROT_CEIL)
         biased = ROT_CEIL;
      return OUT_WIDTH'(biased - ROT_BIAS);
   endfunction

   function automatic rot_vec_type rotate_item(rotate_item_type it);
      bit [63:0] ax, ay, az, ux, uy, uz, f, s0, c0, s, c, oc;
      bit [63:0] xx, yy, zz, xy, xz, yz, sx, sy, sz;
      bit [63:0] m [3][3];
      rot_vec_type res;
      quad_type    quad;
      ax = widen(it.vec_x);
      ay = widen(it.vec_y);
      az = widen(it.vec_z);
      ux = widen(it.axis_x);
      uy = widen(it.axis_y);
      uz = widen(it.axis_z);
      quad = quad_type'(it.angle[15:14]);
      f = 64'(it.angle[13:0]);

      if (f < OCTANT_STEPS)
         octant_sincos(f, s0, c0);
      else
         octant_sincos(QUARTER_STEPS - f, c0, s0);

      case (quad)
         QUAD_0: begin s = s0;        c = c0;        end
         QUAD_1: begin s = c0;        c = 64'd0 - s0; end
         QUAD_2: begin s = 64'd0 - s0; c = 64'd0 - c0; end
         default: begin s = 64'd0 - c0; c = s0;        end
      endcase
      oc = ONE_Q14 - c;

      xx = ux * ux; yy = uy * uy; zz = uz * uz;
      xy = ux * uy; xz = ux * uz; yz = uy * uz;
      sx = ux * s * ONE_Q14;
      sy = uy * s * ONE_Q14;
      sz = uz * s * ONE_Q14;

      m[0][0] = xx * ONE_Q14 + c * (ONE_Q28 - xx);
      m[0][1] = xy * oc - sz;
      m[0][2] = xz * oc + sy;
      m[1][0] = xy * oc + sz;
      m[1][1] = yy * ONE_Q14 + c * (ONE_Q28 - yy);
      m[1][2] = yz * oc - sx;
      m[2][0] = xz * oc - sy;
      m[2][1] = yz * oc + sx;
      m[2][2] = zz * ONE_Q14 + c * (ONE_Q28 - zz);

      for (int r = 0; r < 3; r++)
         res[r] = round_saturate(m[r][0] * ax + m[r][1] * ay + m[r][2] * az);
      return res;
   endfunction

   // ---------------------------------------------------------------- stimulus

   // random gaps between items, with occasional stretches of back-to-back items
   function automatic int unsigned draw_wait();
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      if ($urandom_range(0, 7) == 0) begin
         burst_left = $urandom_range(20, 60);
         return 0;
      end
      return $urandom_range(0, 13);
   endfunction

   function automatic void add_item(int vx, int vy, int vz, int ax, int ay, int az,
                                    int ang, bit drain);
      rotate_item_type it;
      it.vec_x  = COORD_W'(vx);
      it.vec_y  = COORD_W'(vy);
      it.vec_z  = COORD_W'(vz);
      it.axis_x = COORD_W'(ax);
      it.axis_y = COORD_W'(ay);
      it.axis_z = COORD_W'(az);
      it.angle  = ANGLE_WIDTH'(ang);
      it.wait_cycles = draw_wait();
      it.drain  = drain;
      pending.push_back(it);
   endfunction

   function automatic int signed_draw(int lim);
      return int'($urandom_range(0, 2 * lim)) - lim;
   endfunction

   function automatic int pick_extreme(bit coord);
      case ($urandom_range(0, 3))
         0: return coord ? -32768 : -16384;
         1: return coord ? 32767 : 16384;
         2: return 0;
         default: return -1;
      endcase
   endfunction

   // random direction scaled to unit length in Q14
   function automatic void unit_axis(output int ax, output int ay, output int az);
      real x, y, z, len;
      do begin
         x = real'(signed_draw(16384));
         y = real'(signed_draw(16384));
         z = real'(signed_draw(16384));
         len = $sqrt(x * x + y * y + z * z);
      end while (len < 64.0);
      ax = int'(x * 16384.0 / len);
      ay = int'(y * 16384.0 / len);
      az = int'(z * 16384.0 / len);
   endfunction

   function automatic int draw_angle();
      if ($urandom_range(0, 3) == 0)
         return (int'($urandom_range(0, 7)) * 8192 + signed_draw(3)) & 16'hFFFF;
      return $urandom_range(0, 65535);
   endfunction

   initial begin
      int vx, vy, vz, ax, ay, az;
      // quadrant and octant edges about the z axis, then about the x and y axes
      add_item(16384, 0, 0, 0, 0, 16384, 0, 0);
      add_item(16384, 0, 0, 0, 0, 16384, 16384, 0);
      add_item(16384, 0, 0, 0, 0, 16384, 32768, 0);
      add_item(16384, 0, 0, 0, 0, 16384, 49152, 0);
      add_item(16384, 0, 0, 0, 0, 16384, 65535, 0);
      add_item(16384, 16384, 0, 0, 0, 16384, 8192, 0);
      add_item(16384, 16384, 0, 0, 0, 16384, 8191, 0);
      add_item(0, 16384, 16384, 16384, 0, 0, 24576, 0);
      add_item(0, 16384, -16384, 0, -16384, 0, 16383, 0);
      add_item(-16384, 0, 16384, 0, 16384, 0, 16385, 0);
      add_item(12345, -6789, 321, -16384, 0, 0, 32767, 0);
      // non-unit axes driving the sums past either rail, and one unit-axis case
      add_item(32767, 32767, 32767, 16384, 16384, 16384, 32768, 0);
      add_item(-32768, -32768, -32768, 16384, 16384, 16384, 32768, 0);
      add_item(32767, -32768, 32767, -16384, -16384, -16384, 57344, 0);
      add_item(-32768, 32767, -32768, 16384, -16384, 16384, 40000, 0);
      add_item(32767, -32768, 32767, -16384, 0, 0, 16384, 0);
      // zero axis leaves only the cosine term, followed by a zero vector and other corner cases
      add_item(32767, -32768, 12000, 0, 0, 0, 4096, 0);
      add_item(0, 0, 0, 16384, 16384, -16384, 12345, 0);
      add_item(-1, -1, -1, -1, -1, -1, 65535, 0);
      add_item(1, 1, 1, 1, 1, 1, 1, 0);
      add_item(-32768, -32768, -32768, -16384, -16384, -16384, 0, 0);
      add_item(32767, 32767, 32767, 0, 11585, 11585, 20480, 0);
      directed_items = pending.size();

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
               unit_axis(ax, ay, az);
               vx = int'($urandom_range(0, 65535)) - 32768;
               vy = int'($urandom_range(0, 65535)) - 32768;
               vz = int'($urandom_range(0, 65535)) - 32768;
            end
            6, 7: begin
               ax = signed_draw(16384);
               ay = signed_draw(16384);
               az = signed_draw(16384);
               vx = int'($urandom_range(0, 65535)) - 32768;
               vy = int'($urandom_range(0, 65535)) - 32768;
               vz = int'($urandom_range(0, 65535)) - 32768;
            end
            8: begin
               ax = pick_extreme(0);
               ay = pick_extreme(0);
               az = pick_extreme(0);
               vx = pick_extreme(1);
               vy = pick_extreme(1);
               vz = pick_extreme(1);
            end
            default: begin
               unit_axis(ax, ay, az);
               vx = signed_draw(64);
               vy = signed_draw(64);
               vz = signed_draw(64);
            end
         endcase
         add_item(vx, vy, vz, ax, ay, az, draw_angle(), (i % DRAIN_EVERY) == 0);
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   // ---------------------------------------------------------------- driver

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         idle_count = 0;
      end else begin
         if (start && !busy) begin
            rotations_due.push_back(rotate_item(in_flight));
            items_accepted++;
         end
         // the slot is free when nothing is offered or the offer was just taken
         if (!start || !busy) begin
            if (pending.size() == 0) begin
               start <= 1'b0;
            end else if (pending[0].drain && rotations_due.size() != 0) begin
               if (idle_count == 0)
                  drain_pauses++;
               idle_count = 1;
               start <= 1'b0;
            end else if (idle_count < pending[0].wait_cycles) begin
               idle_count++;
               start <= 1'b0;
            end else begin
               in_flight = pending.pop_front();
               idle_count = 0;
               req_vec_x  <= in_flight.vec_x;
               req_vec_y  <= in_flight.vec_y;
               req_vec_z  <= in_flight.vec_z;
               req_axis_x <= in_flight.axis_x;
               req_axis_y <= in_flight.axis_y;
               req_axis_z <= in_flight.axis_z;
               req_angle  <= in_flight.angle;
               start <= 1'b1;
            end
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin
      rot_vec_type got, want;
      if (!reset && rsp_valid) begin
         got = {rsp_rot_z, rsp_rot_y, rsp_rot_x};
         if (rotations_due.size() == 0) begin
            $display("%t: result with no item outstanding: x=%0d y=%0d z=%0d", $time,
                     rsp_rot_x, rsp_rot_y, rsp_rot_z);
            errors++;
         end else begin
            want = rotations_due.pop_front();
            for (int k = 0; k < 3; k++) begin
               if (got[k] !== want[k]) begin
                  $display("%t: rot_%s mismatch: expected %0d, actual %0d", $time,
                           (k == 0) ? "x" : (k == 1) ? "y" : "z",
                           $signed(want[k]), $signed(got[k]));
                  errors++;
               end
            end
            results_checked++;
         end
         if (rsp_rot_x inside {ROT_MAX, ROT_MIN} || rsp_rot_y inside {ROT_MAX, ROT_MIN} ||
             rsp_rot_z inside {ROT_MAX, ROT_MIN})
            saturated++;
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results still due", cycles,
                  rotations_due.size());
         $display("Some tests failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- end of run

   initial begin
      @(negedge reset);
      while (pending.size() != 0 || start || rotations_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Rotated %0d vectors (%0d directed, rest random), %0d results checked",
               items_accepted, directed_items, results_checked);
      $display("%0d results hit a rail, %0d full drain pauses", saturated, drain_pauses);
      if (errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

FILE: axis_angle_vector_rotate.f
rtl/core/aavr_pkg.sv
rtl/core/aavr_sincos.sv
rtl/core/axis_angle_vector_rotate.sv
rtl/core/aavr_checker.sv
tb/sv/tb_axis_angle_vector_rotate.sv
